### design/event_metric_aggregator_assert.svh
// Assertion macros shared by the aggregator RTL.
`ifndef EVENT_METRIC_AGGREGATOR_ASSERT_SVH
`define EVENT_METRIC_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ema_pkg.sv
// Shared constants and types for the event metric aggregator.
package ema_pkg;

  localparam int OP_W      = 4;
  localparam int AMT_W     = 32;
  localparam int EL_W      = 40;
  localparam int RATE_W    = 40;
  localparam int CORE_W    = 11;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam int ACC_DEPTH = 8;
  localparam int ACC_AW    = 3;
  localparam int ACC_W     = 64;

  // Multiplier: A is up to a 65-bit paired sum, B up to a 40-bit rate.
  localparam int MUL_AW      = 65;
  localparam int MUL_BW      = 40;
  localparam int MUL_DIGIT_W = 8;
  localparam int MUL_STEPS   = MUL_BW / MUL_DIGIT_W;
  localparam int MUL_CW      = 3;
  localparam int PROD_W      = 96;

  // Percent unit: t = 200*n + d and the shifted divisor.
  localparam int DIV_W     = 104;
  localparam int PCT_STEPS = 7;
  localparam int PCT_CW    = 3;

  localparam logic [PCT_W-1:0]  PCT_MAX           = PCT_W'(100);
  localparam logic [RATE_W-1:0] DEFAULT_LINK_RATE = RATE_W'(125000000);
  localparam logic [CORE_W-1:0] CORE_RESET        = CORE_W'(1);
  localparam logic [MUL_BW-1:0] NS_PER_SEC        = MUL_BW'(1000000000);

  // Opcodes
  localparam logic [OP_W-1:0] OP_TX_BYTES   = 4'd0;
  localparam logic [OP_W-1:0] OP_RX_BYTES   = 4'd1;
  localparam logic [OP_W-1:0] OP_TX_LAT     = 4'd2;
  localparam logic [OP_W-1:0] OP_RX_LAT     = 4'd3;
  localparam logic [OP_W-1:0] OP_BLOCK_DONE = 4'd4;
  localparam logic [OP_W-1:0] OP_SCHED      = 4'd5;
  localparam logic [OP_W-1:0] OP_LLC_REFS   = 4'd6;
  localparam logic [OP_W-1:0] OP_LLC_MISS   = 4'd7;
  localparam logic [OP_W-1:0] OP_TICK       = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT = 2'd1;

  // Sequencer request into the accumulator store: read and zero one entry.
  typedef struct packed {
    logic              sweep;
    logic [ACC_AW-1:0] addr;
  } acc_req_t;

endpackage

### design/ema_accum.sv
// Accumulator store: 8x64 memory with event read-modify-write and sweep reads.
module ema_accum import ema_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ev_valid,
  input  logic [ACC_AW-1:0] ev_addr,
  input  logic [AMT_W-1:0]  ev_amount,
  input  acc_req_t          seq_req,
  output logic [ACC_W-1:0]  rd_data
);

  logic [ACC_W-1:0]     mem [ACC_DEPTH];
  logic [ACC_DEPTH-1:0] vld_r;
  logic [ACC_W-1:0]     rd_data_r;
  logic                 rd_vld_r;

  logic                 s1_v_r;
  logic [ACC_AW-1:0]    s1_addr_r;
  logic [AMT_W-1:0]     s1_amt_r;

  logic                 fwd_v_r;
  logic [ACC_AW-1:0]    fwd_addr_r;
  logic [ACC_W-1:0]     fwd_data_r;

  logic [ACC_AW-1:0]    rd_addr;
  logic                 rd_en;
  logic [ACC_W-1:0]     base;
  logic [ACC_W-1:0]     sum;

  assign rd_addr = ev_valid ? ev_addr : seq_req.addr;
  assign rd_en   = ev_valid | seq_req.sweep;
  assign rd_data = rd_vld_r ? rd_data_r : '0;

  // previous write has not reached the read port yet
  assign base = (fwd_v_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rd_data;
  assign sum  = base + ACC_W'(s1_amt_r);

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem[s1_addr_r] <= sum;
    end else if (seq_req.sweep) begin
      mem[seq_req.addr] <= '0;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    s1_addr_r  <= ev_addr;
    s1_amt_r   <= ev_amount;
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      s1_v_r   <= 1'b0;
      fwd_v_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (s1_v_r) begin
        vld_r[s1_addr_r] <= 1'b1;
      end else if (seq_req.sweep) begin
        vld_r[seq_req.addr] <= 1'b0;
      end
      s1_v_r <= ev_valid;
      // bypass only holds the write of the cycle just before
      fwd_v_r <= s1_v_r;
    end
  end

endmodule

### design/ema_mul.sv
// Digit-serial multiplier: 8 bits of B per cycle.
module ema_mul import ema_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_AW-1:0] op_a,
  input  logic [MUL_BW-1:0] op_b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] a_sh_r;
  logic [MUL_BW-1:0] b_sh_r;
  logic [PROD_W-1:0] acc_r;
  logic [MUL_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PROD_W-1:0] part;

  assign part = a_sh_r * PROD_W'(b_sh_r[MUL_DIGIT_W-1:0]);
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= PROD_W'(op_a);
      b_sh_r <= op_b;
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r  <= acc_r + part;
      a_sh_r <= a_sh_r << MUL_DIGIT_W;
      b_sh_r <= b_sh_r >> MUL_DIGIT_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CW'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### design/ema_pct.sv
// Rounded percentage floor((200n+d)/2d) by restoring division, one bit a cycle.
module ema_pct import ema_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [PROD_W-1:0] den,
  output logic              done,
  output logic [PCT_W-1:0]  pct
);

  logic [DIV_W-1:0]  t_r;
  logic [DIV_W-1:0]  stp_r;
  logic [PCT_W-1:0]  q_r;
  logic              dz_r;
  logic              big_r;
  logic [PCT_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PCT_W-1:0]  pct_r;

  logic [DIV_W-1:0]  num_x;
  logic [DIV_W-1:0]  t_init;
  logic              ge;
  logic [PCT_W-1:0]  q_fin;

  assign num_x  = DIV_W'(num);
  // 200n = 128n + 64n + 8n
  assign t_init = (num_x << 7) + (num_x << 6) + (num_x << 3) + DIV_W'(den);
  assign ge     = (t_r >= stp_r);
  assign q_fin  = {q_r[PCT_W-2:0], ge};
  assign done   = done_r;
  assign pct    = pct_r;

  always_ff @(posedge clk) begin
    if (start) begin
      t_r   <= t_init;
      stp_r <= DIV_W'(den) << PCT_STEPS;
      q_r   <= '0;
      dz_r  <= (den == '0);
      big_r <= (num >= den);
    end else if (busy_r) begin
      if (ge) begin
        t_r <= t_r - stp_r;
      end
      stp_r <= stp_r >> 1;
      q_r   <= q_fin;
      if (cnt_r == PCT_CW'(PCT_STEPS - 1)) begin
        if (dz_r) begin
          pct_r <= '0;
        end else if (big_r || (q_fin > PCT_MAX)) begin
          pct_r <= PCT_MAX;
        end else begin
          pct_r <= q_fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == PCT_CW'(PCT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### design/event_metric_aggregator.sv
// Top level: performance-monitor aggregator, five percentages per tick.
//
// Input channel (in_valid/in_ready): one beat per event or tick. Opcodes 0..7
// add in_amount to one of eight 64-bit accumulators held in a small memory;
// opcode 8 (tick) turns the totals into five rounded percentages and zeroes
// them; opcodes 9..15 are taken and dropped.
// Events: one beat per cycle sustained while no tick is in progress. Each does
// a read-modify-write on the accumulator memory (registered read); a one-entry
// bypass covers back-to-back beats to the same counter. Events never produce an
// output beat. Ticks: from acceptance to the output beat the sequencer walks
// the five metrics through one restoring percent divider (7 steps); net util
// and CPU first use one shared 8-bit-per-cycle multiplier (5 steps). in_ready
// stays low for that span.
// Output channel (out_valid/out_ready): one beat per tick, held in an output
// register. Events are still taken while a result waits; a following tick
// finishes its math and then holds until the output register is free.
// Config (cfg_valid/cfg_ready, always ready): index 0 link rate in bytes/s,
// index 1 core count; write only while idle.
// Reset (rst_n low, synchronous): accumulators read as zero, link rate
// 125000000, core count 1, no output pending.
module event_metric_aggregator import ema_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [AMT_W-1:0]     in_amount,
  input  logic [EL_W-1:0]      in_elapsed_ns,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PCT_W-1:0]     out_net_util_pct,
  output logic [PCT_W-1:0]     out_net_stack_pct,
  output logic [PCT_W-1:0]     out_block_pct,
  output logic [PCT_W-1:0]     out_cpu_pct,
  output logic [PCT_W-1:0]     out_llc_miss_pct,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data
);

  `include "event_metric_aggregator_assert.svh"

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_RD_A     = 4'd1;
  localparam logic [ST_W-1:0] ST_RD_B     = 4'd2;
  localparam logic [ST_W-1:0] ST_CAP      = 4'd3;
  localparam logic [ST_W-1:0] ST_MUL_N_GO = 4'd4;
  localparam logic [ST_W-1:0] ST_MUL_N_WT = 4'd5;
  localparam logic [ST_W-1:0] ST_MUL_D_GO = 4'd6;
  localparam logic [ST_W-1:0] ST_MUL_D_WT = 4'd7;
  localparam logic [ST_W-1:0] ST_PCT_GO   = 4'd8;
  localparam logic [ST_W-1:0] ST_PCT_WT   = 4'd9;
  localparam logic [ST_W-1:0] ST_OUT      = 4'd10;

  localparam int MET_N  = 5;
  localparam int MET_W  = 3;
  localparam logic [MET_W-1:0] MET_NET_UTIL  = 3'd0;
  localparam logic [MET_W-1:0] MET_NET_STACK = 3'd1;
  localparam logic [MET_W-1:0] MET_BLOCK     = 3'd2;
  localparam logic [MET_W-1:0] MET_CPU       = 3'd3;
  localparam logic [MET_W-1:0] MET_LLC       = 3'd4;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [MET_W-1:0]  met_r;
  logic [EL_W-1:0]   el_r;
  logic [PROD_W-1:0] num_r;
  logic [PROD_W-1:0] den_r;
  logic [PCT_W-1:0]  res_r [MET_N];
  logic [PCT_W-1:0]  out_res_r [MET_N];
  logic              out_valid_r;
  logic [RATE_W-1:0] link_rate_r;
  logic [CORE_W-1:0] core_cnt_r;

  logic              in_fire;
  logic              tick_fire;
  logic              ev_valid;
  logic              out_free;
  logic [RATE_W-1:0] rate_eff;
  logic [CORE_W-1:0] cores_eff;
  acc_req_t          acc_req;
  logic [ACC_W-1:0]  acc_rd;
  logic [ACC_AW-1:0] entry_a;
  logic [ACC_AW-1:0] entry_b;

  logic              mul_start;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;

  logic              pct_start;
  logic              pct_done;
  logic [PCT_W-1:0]  pct_val;

  // ---------------- handshakes ----------------
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign tick_fire = in_fire && (in_opcode == OP_TICK);
  assign ev_valid  = in_fire && !in_opcode[OP_W-1];
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  assign out_net_util_pct  = out_res_r[MET_NET_UTIL];
  assign out_net_stack_pct = out_res_r[MET_NET_STACK];
  assign out_block_pct     = out_res_r[MET_BLOCK];
  assign out_cpu_pct       = out_res_r[MET_CPU];
  assign out_llc_miss_pct  = out_res_r[MET_LLC];

  assign rate_eff  = (link_rate_r == '0) ? DEFAULT_LINK_RATE : link_rate_r;
  assign cores_eff = (core_cnt_r == '0) ? CORE_RESET : core_cnt_r;

  // ---------------- accumulator entries per metric ----------------
  // Single-counter metrics read their entry twice; the second read sees the
  // zero just written and adds nothing.
  always_comb begin
    case (met_r)
      MET_NET_UTIL: begin
        entry_a = OP_TX_BYTES[ACC_AW-1:0];
        entry_b = OP_RX_BYTES[ACC_AW-1:0];
      end
      MET_NET_STACK: begin
        entry_a = OP_TX_LAT[ACC_AW-1:0];
        entry_b = OP_RX_LAT[ACC_AW-1:0];
      end
      MET_BLOCK: begin
        entry_a = OP_BLOCK_DONE[ACC_AW-1:0];
        entry_b = OP_BLOCK_DONE[ACC_AW-1:0];
      end
      MET_CPU: begin
        entry_a = OP_SCHED[ACC_AW-1:0];
        entry_b = OP_SCHED[ACC_AW-1:0];
      end
      default: begin
        entry_a = OP_LLC_MISS[ACC_AW-1:0];
        entry_b = OP_LLC_REFS[ACC_AW-1:0];
      end
    endcase
  end

  // each sweep read also zeroes the entry it reads
  assign acc_req.sweep = (state_r == ST_RD_A) || (state_r == ST_RD_B);
  assign acc_req.addr  = (state_r == ST_RD_A) ? entry_a : entry_b;

  ema_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev_addr   (in_opcode[ACC_AW-1:0]),
    .ev_amount (in_amount),
    .seq_req   (acc_req),
    .rd_data   (acc_rd)
  );

  // ---------------- arithmetic units ----------------
  // numerator scale: (tx+rx bytes) * 1e9; denominators: el*rate, el*cores
  assign mul_start = (state_r == ST_MUL_N_GO) || (state_r == ST_MUL_D_GO);
  assign mul_a     = (state_r == ST_MUL_N_GO) ? num_r[MUL_AW-1:0] : MUL_AW'(el_r);
  assign mul_b     = (state_r == ST_MUL_N_GO) ? NS_PER_SEC :
                     (met_r == MET_NET_UTIL)  ? rate_eff : MUL_BW'(cores_eff);

  ema_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign pct_start = (state_r == ST_PCT_GO);

  ema_pct u_pct (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pct_start),
    .num   (num_r),
    .den   (den_r),
    .done  (pct_done),
    .pct   (pct_val)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (tick_fire) state_nxt = ST_RD_A;
      ST_RD_A:     state_nxt = ST_RD_B;
      ST_RD_B:     state_nxt = ST_CAP;
      ST_CAP: begin
        if (met_r == MET_NET_UTIL) begin
          state_nxt = ST_MUL_N_GO;
        end else if (met_r == MET_CPU) begin
          state_nxt = ST_MUL_D_GO;
        end else begin
          state_nxt = ST_PCT_GO;
        end
      end
      ST_MUL_N_GO: state_nxt = ST_MUL_N_WT;
      ST_MUL_N_WT: if (mul_done) state_nxt = ST_MUL_D_GO;
      ST_MUL_D_GO: state_nxt = ST_MUL_D_WT;
      ST_MUL_D_WT: if (mul_done) state_nxt = ST_PCT_GO;
      ST_PCT_GO:   state_nxt = ST_PCT_WT;
      ST_PCT_WT: begin
        if (pct_done) begin
          state_nxt = (met_r == MET_LLC) ? ST_OUT : ST_RD_A;
        end
      end
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      el_r <= in_elapsed_ns;
    end
    case (state_r)
      ST_RD_B: begin
        num_r <= PROD_W'(acc_rd);
      end
      ST_CAP: begin
        if (met_r == MET_LLC) begin
          den_r <= PROD_W'(acc_rd);
        end else begin
          num_r <= num_r + PROD_W'(acc_rd);
        end
        if ((met_r == MET_NET_STACK) || (met_r == MET_BLOCK)) begin
          den_r <= PROD_W'(el_r);
        end
      end
      ST_MUL_N_WT: if (mul_done) num_r <= mul_prod;
      ST_MUL_D_WT: if (mul_done) den_r <= mul_prod;
      ST_PCT_WT:   if (pct_done) res_r[met_r] <= pct_val;
      ST_OUT: begin
        if (out_free) begin
          out_res_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      met_r       <= MET_NET_UTIL;
      out_valid_r <= 1'b0;
      link_rate_r <= DEFAULT_LINK_RATE;
      core_cnt_r  <= CORE_RESET;
    end else begin
      state_r <= state_nxt;
      if (tick_fire) begin
        met_r <= MET_NET_UTIL;
      end else if ((state_r == ST_PCT_WT) && pct_done && (met_r != MET_LLC)) begin
        met_r <= met_r + 1'b1;
      end
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LINK_RATE:  link_rate_r <= cfg_data;
          CFG_CORE_COUNT: core_cnt_r  <= cfg_data[CORE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- assertions ----------------
  `EMA_ASSERT_NXT(a_tick_starts_sweep, tick_fire, (state_r == ST_RD_A) && (met_r == MET_NET_UTIL), "tick did not start at first metric")
  `EMA_ASSERT_NXT(a_out_load, (state_r == ST_OUT) && out_free, out_valid_r && (state_r == ST_IDLE), "result not loaded into output register")
  `EMA_ASSERT_IMP(a_mul_done_expected, mul_done, (state_r == ST_MUL_N_WT) || (state_r == ST_MUL_D_WT), "multiplier finished outside a wait state")
  `EMA_ASSERT_IMP(a_pct_range, pct_done, (pct_val <= PCT_MAX) && (state_r == ST_PCT_WT), "percent out of range or unexpected")
  `EMA_ASSERT_IMP(a_met_range, state_r != ST_IDLE, met_r <= MET_LLC, "metric index out of range")

endmodule

### tb/testbench.sv
// Self-checking testbench for event_metric_aggregator: events, ticks and config phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ema_pkg::*;

  // Opcodes the block takes and drops, and a register index that holds nothing.
  localparam logic [OP_W-1:0]      OP_SPARE_LO = 4'd9;
  localparam logic [OP_W-1:0]      OP_SPARE_HI = 4'd15;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  localparam logic [RATE_W-1:0] LINK_RATE_MAX = 40'd1000000000000;
  localparam logic [CORE_W-1:0] CORE_MAX      = 11'd1024;

  localparam int PHASE_ITEMS  = 85;     // counted beats per random phase
  localparam int HOLD_CYCLES  = 600;    // long out_ready hold-off
  localparam int SETTLE_TICKS = 120;
  localparam int CYCLE_LIMIT  = 400000;

  // Expected-percentage tracker: mirrors the eight counters and both registers,
  // turns each tick into five rounded percentages and checks the output beats.
  class metric_tally;
    typedef struct {
      logic [PCT_W-1:0] net_util;
      logic [PCT_W-1:0] net_stack;
      logic [PCT_W-1:0] block;
      logic [PCT_W-1:0] cpu;
      logic [PCT_W-1:0] llc_miss;
    } pct_set_t;

    logic [ACC_W-1:0]  totals [ACC_DEPTH];
    logic [RATE_W-1:0] link_rate;
    logic [CORE_W-1:0] cores;
    pct_set_t          pct_queue [$];
    int                errors;

    function new();
      errors    = 0;
      link_rate = DEFAULT_LINK_RATE;
      cores     = CORE_RESET;
      foreach (totals[i]) totals[i] = '0;
    endfunction

    function int pending();
      return pct_queue.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
      if (idx == CFG_LINK_RATE) link_rate = data;
      else if (idx == CFG_CORE_COUNT) cores = data[CORE_W-1:0];
    endfunction

    // floor(100*num/den + 1/2), capped at 100; zero denominator gives 0
    function logic [PCT_W-1:0] rounded_pct(logic [127:0] num, logic [127:0] den);
      logic [127:0] q;
      if (den == 0) return '0;
      if (num >= den) return PCT_MAX;
      q = (num * 128'd200 + den) / (den << 1);
      return (q > 128'd100) ? PCT_MAX : q[PCT_W-1:0];
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [AMT_W-1:0] amount,
                             logic [EL_W-1:0] elapsed);
      logic [RATE_W-1:0] rate;
      logic [CORE_W-1:0] ncores;
      pct_set_t          want;
      if (op < OP_TICK) begin
        totals[op[ACC_AW-1:0]] += ACC_W'(amount);
        return;
      end
      if (op != OP_TICK) return;
      rate   = (link_rate != 0) ? link_rate : DEFAULT_LINK_RATE;
      ncores = (cores != 0) ? cores : CORE_RESET;
      want.net_util  = rounded_pct((128'(totals[OP_TX_BYTES[ACC_AW-1:0]])
                                    + 128'(totals[OP_RX_BYTES[ACC_AW-1:0]]))
                                   * 128'(NS_PER_SEC), 128'(elapsed) * 128'(rate));
      want.net_stack = rounded_pct(128'(totals[OP_TX_LAT[ACC_AW-1:0]])
                                   + 128'(totals[OP_RX_LAT[ACC_AW-1:0]]),
                                   128'(elapsed));
      want.block     = rounded_pct(128'(totals[OP_BLOCK_DONE[ACC_AW-1:0]]),
                                   128'(elapsed));
      want.cpu       = rounded_pct(128'(totals[OP_SCHED[ACC_AW-1:0]]),
                                   128'(elapsed) * 128'(ncores));
      want.llc_miss  = rounded_pct(128'(totals[OP_LLC_MISS[ACC_AW-1:0]]),
                                   128'(totals[OP_LLC_REFS[ACC_AW-1:0]]));
      pct_queue.push_back(want);
      foreach (totals[i]) totals[i] = '0;
    endfunction

    function void compare_field(string name, logic [PCT_W-1:0] want, logic [PCT_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [PCT_W-1:0] net_util, logic [PCT_W-1:0] net_stack,
                               logic [PCT_W-1:0] block, logic [PCT_W-1:0] cpu,
                               logic [PCT_W-1:0] llc_miss);
      pct_set_t want;
      if (pct_queue.size() == 0) begin
        $error("result beat with no tick outstanding");
        errors++;
        return;
      end
      want = pct_queue.pop_front();
      compare_field("net_util_pct", want.net_util, net_util);
      compare_field("net_stack_pct", want.net_stack, net_stack);
      compare_field("block_pct", want.block, block);
      compare_field("cpu_pct", want.cpu, cpu);
      compare_field("llc_miss_pct", want.llc_miss, llc_miss);
    endfunction
  endclass

  // Clock and synchronous reset; every input known from time zero.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode     = '0;
  logic [AMT_W-1:0]     in_amount     = '0;
  logic [EL_W-1:0]      in_elapsed_ns = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [PCT_W-1:0]     out_net_util_pct;
  logic [PCT_W-1:0]     out_net_stack_pct;
  logic [PCT_W-1:0]     out_block_pct;
  logic [PCT_W-1:0]     out_cpu_pct;
  logic [PCT_W-1:0]     out_llc_miss_pct;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [RATE_W-1:0]    cfg_data      = '0;

  metric_tally board;
  int          items_done  = 0;   // accepted events and ticks, spare opcodes not counted
  bit          tx_calm     = 1'b0;
  int          hold_req    = 0;   // bumped by the sequence to request a long hold-off
  int          cycle_count = 0;

  always #6 clk = ~clk;

  event_metric_aggregator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_amount         (in_amount),
    .in_elapsed_ns     (in_elapsed_ns),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_net_util_pct  (out_net_util_pct),
    .out_net_stack_pct (out_net_stack_pct),
    .out_block_pct     (out_block_pct),
    .out_cpu_pct       (out_cpu_pct),
    .out_llc_miss_pct  (out_llc_miss_pct),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  function automatic logic [39:0] rand40();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side. Sampling in the active region of the edge sees the values the
  // block presented at that edge. After every beat a fresh random hold-off is
  // drawn (forced to none a quarter of the time), and a bump of hold_req starts
  // a long hold-off that backs the block up into its input.
  always @(posedge clk) begin : result_sink
    int rx_wait;
    int rx_hold;
    int hold_seen;
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_net_util_pct, out_net_stack_pct, out_block_pct,
                         out_cpu_pct, out_llc_miss_pct);
      rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      rx_hold   = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input beat. valid drops only when a gap is drawn, so back-to-back beats
  // keep it high with a single assignment per step.
  task automatic push_item(logic [OP_W-1:0] op, logic [AMT_W-1:0] amount,
                           logic [EL_W-1:0] elapsed);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_amount     <= amount;
    in_elapsed_ns <= elapsed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(op, amount, elapsed);
    if (op <= OP_TICK) items_done++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Both registers back to back; optionally a write to the empty index too.
  task automatic set_config(logic [RATE_W-1:0] rate, logic [RATE_W-1:0] core_word,
                            bit poke_spare);
    write_cfg(CFG_LINK_RATE, rate);
    write_cfg(CFG_CORE_COUNT, core_word);
    if (poke_spare) write_cfg(CFG_SPARE, rand40());
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait for every outstanding tick result.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Fully idle: results drained, plus room for an event or a dropped beat in flight.
  task automatic settle();
    wait_results();
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // A measurement interval: a burst of events at one magnitude, an occasional
  // spare opcode, then a tick whose elapsed time sits near that magnitude so the
  // percentages land across 0..100. Empty intervals and zero elapsed time occur.
  task automatic run_window();
    int               n_ev;
    int               scale;
    int               el_bits;
    logic [OP_W-1:0]  op;
    logic [AMT_W-1:0] amount;
    logic [EL_W-1:0]  elapsed;
    n_ev    = $urandom_range(0, 12);
    scale   = $urandom_range(0, 32);
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_ev; i++) begin
      if ($urandom_range(0, 15) == 0) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else op = OP_W'($urandom_range(OP_TX_BYTES, OP_LLC_MISS));
      amount = 32'($urandom) >> (32 - scale);
      push_item(op, amount, rand40());
    end
    el_bits = scale + $urandom_range(0, 8);
    if (el_bits > EL_W) el_bits = EL_W;
    elapsed = ($urandom_range(0, 19) == 0) ? '0 : rand40() >> (EL_W - el_bits);
    push_item(OP_TICK, $urandom, elapsed);
  endtask

  initial begin : sequence_main
    logic [RATE_W-1:0] rate;
    int                target;
    bit                paused;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings (125000000 B/s, one core).
    // Tick on empty counters: every denominator is zero.
    push_item(OP_TICK, '0, '0);
    // Largest amounts, zero and one, refs with no misses, spare opcodes.
    push_item(OP_TX_BYTES, '1, '0);
    push_item(OP_RX_BYTES, '1, '0);
    push_item(OP_TX_LAT, '1, '1);
    push_item(OP_RX_LAT, '1, '0);
    push_item(OP_BLOCK_DONE, '0, '1);
    push_item(OP_SCHED, 32'd1, '0);
    push_item(OP_LLC_REFS, '1, '0);
    push_item(OP_LLC_MISS, '0, '0);
    push_item(OP_SPARE_LO, '1, '1);
    push_item(OP_SPARE_HI, '1, '0);
    push_item(OP_TICK, '1, '1);
    // Exact halves round up; byte rate meets the link rate exactly and gives 100.
    push_item(OP_LLC_REFS, 32'd200, '0);
    push_item(OP_LLC_MISS, 32'd1, '0);
    push_item(OP_BLOCK_DONE, 32'd1, '0);
    push_item(OP_SCHED, 32'd3, '0);
    push_item(OP_TX_BYTES, 32'd25, '0);
    push_item(OP_TICK, '0, 40'd200);
    // Latency and misses above their denominators clamp at 100.
    push_item(OP_TX_LAT, 32'd1000, '0);
    push_item(OP_LLC_MISS, 32'd9, '0);
    push_item(OP_LLC_REFS, 32'd4, '0);
    push_item(OP_TICK, '0, 40'd10);
    // Just under a half rounds down; 99.5 rounds up to 100 without clamping.
    push_item(OP_RX_LAT, 32'd49, '0);
    push_item(OP_SCHED, 32'd9950, '0);
    push_item(OP_TICK, '0, 40'd10000);
    settle();

    // Random phases, each under its own register setting.
    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: set_config('0, '0, 1'b0);                           // zero means defaults
        2: set_config(LINK_RATE_MAX, RATE_W'(CORE_MAX), 1'b0);
        3: set_config(40'd1, 40'd1, 1'b1);
        default: begin
          rate = rand40() >> $urandom_range(0, 40);
          if (rate > LINK_RATE_MAX) rate = LINK_RATE_MAX;
          set_config(rate, {29'($urandom), 11'($urandom_range(0, CORE_MAX))}, 1'b0);
        end
      endcase
      // Long result hold-off while beats keep coming.
      if (ph == 1 || ph == 4) hold_req <= hold_req + 1;
      target = items_done + PHASE_ITEMS;
      paused = 1'b0;
      while (items_done < target) begin
        run_window();
        // Once per phase the sender stops until every result is back.
        if (!paused && items_done >= target - PHASE_ITEMS / 2) begin
          wait_results();
          paused = 1'b1;
        end
      end
      settle();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/ema_pkg.sv
design/ema_accum.sv
design/ema_mul.sv
design/ema_pct.sv
design/event_metric_aggregator.sv
tb/testbench.sv
